// ===== rtl/core/bipartite_edge_swap_engine_top_assert.svh =====
// Assertion macros shared by the edge swap engine.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef BIPARTITE_EDGE_SWAP_ENGINE_TOP_ASSERT_SVH
`define BIPARTITE_EDGE_SWAP_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BES_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BES_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BES_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define BES_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== rtl/core/bes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

  localparam int EDGE_AW    = 16;
  localparam int NODE_AW    = 16;
  localparam int EDGE_DEPTH = 1 << EDGE_AW;
  localparam int NODE_DEPTH = 1 << NODE_AW;
  localparam int MAX_EDGES  = EDGE_DEPTH;
  localparam int CNT_W      = EDGE_AW + 1;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_WR_EDGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_NODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWAP    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_EDGE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SWAPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SAME    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LINK    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [EDGE_AW-1:0] edge_a;
    logic [EDGE_AW-1:0] edge_b;
    logic [NODE_AW-1:0] top_node;
    logic [NODE_AW-1:0] bottom_node;
    logic [EDGE_AW-1:0] first_edge;
    logic [CNT_W-1:0]   node_degree;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_AW-1:0]  read_top;
    logic [NODE_AW-1:0]  read_bottom;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                cap_in;
    logic                wr_edge;
    logic                wr_node;
    logic                rd_a;
    logic                rd_b;
    logic                cap_a;
    logic                cap_b;
    logic                cap_rd;
    logic                rd_node;
    logic                node_sel;
    logic                set_range;
    logic                scan_step;
    logic                wr_swap_a;
    logic                wr_swap_b;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             same_edge;
    logic             out_of_range;
    logic             scan_done;
    logic             hit;
    logic             out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bes_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bes_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bes_pkg::CNT_W-1:0]   cfg_wr_data,
  input  bes_pkg::in_item_t           in_item,
  input  bes_pkg::dp_cmd_t            cmd,
  output bes_pkg::dp_sts_t            sts,
  input  logic                        m_ready,
  output logic                        out_valid,
  output bes_pkg::out_item_t          out_item
);
  import bes_pkg::*;

  logic [CNT_W-1:0]    edge_count;
  logic [CNT_W-1:0]    lim;
  in_item_t            item;

  logic [NODE_AW-1:0]  edge_top_mem [EDGE_DEPTH];
  logic [NODE_AW-1:0]  edge_bot_mem [EDGE_DEPTH];
  logic [EDGE_AW-1:0]  node_first_mem [NODE_DEPTH];
  logic [CNT_W-1:0]    node_deg_mem [NODE_DEPTH];

  logic [NODE_AW-1:0]  top_q;
  logic [NODE_AW-1:0]  bot_q;
  logic [EDGE_AW-1:0]  first_q;
  logic [CNT_W-1:0]    deg_q;

  logic [NODE_AW-1:0]  top_a;
  logic [NODE_AW-1:0]  bot_a;
  logic [NODE_AW-1:0]  top_b;
  logic [NODE_AW-1:0]  bot_b;

  logic [CNT_W-1:0]    scan_idx;
  logic [CNT_W-1:0]    scan_stop;
  logic                scan_pend;
  logic                scan_hit;
  logic                scan_pass;
  logic                scan_more;
  logic [NODE_AW-1:0]  scan_target;

  logic [STATUS_W-1:0] res_status;
  logic [NODE_AW-1:0]  res_top;
  logic [NODE_AW-1:0]  res_bot;

  logic [EDGE_AW-1:0]  edge_raddr;
  logic [EDGE_AW-1:0]  bot_raddr;
  logic                bot_we;
  logic [EDGE_AW-1:0]  bot_waddr;
  logic [NODE_AW-1:0]  bot_wdata;
  logic [NODE_AW-1:0]  node_raddr;
  logic [CNT_W:0]      range_sum;
  logic [CNT_W-1:0]    range_stop;

  assign lim = (edge_count > CNT_W'(MAX_EDGES)) ? CNT_W'(MAX_EDGES) : edge_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (cfg_wr_en) begin
      edge_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      item <= in_item;
    end
  end

  // Edge memories.
  assign edge_raddr = cmd.rd_b ? item.edge_b : item.edge_a;
  assign bot_raddr  = cmd.scan_step ? scan_idx[EDGE_AW-1:0] : edge_raddr;
  assign bot_we     = cmd.wr_edge | cmd.wr_swap_a | cmd.wr_swap_b;
  assign bot_waddr  = cmd.wr_swap_b ? item.edge_b : item.edge_a;
  assign bot_wdata  = cmd.wr_edge ? item.bottom_node : (cmd.wr_swap_a ? bot_b : bot_a);

  always_ff @(posedge clk) begin
    if (cmd.wr_edge) begin
      edge_top_mem[item.edge_a] <= item.top_node;
    end
    top_q <= edge_top_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (bot_we) begin
      edge_bot_mem[bot_waddr] <= bot_wdata;
    end
    bot_q <= edge_bot_mem[bot_raddr];
  end

  // Node memories.
  assign node_raddr = cmd.node_sel ? top_b : top_a;

  always_ff @(posedge clk) begin
    if (cmd.wr_node) begin
      node_first_mem[item.top_node] <= item.first_edge;
    end
    first_q <= node_first_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_node) begin
      node_deg_mem[item.top_node] <= item.node_degree;
    end
    deg_q <= node_deg_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      top_a <= top_q;
      bot_a <= bot_q;
    end
    if (cmd.cap_b) begin
      top_b <= top_q;
      bot_b <= bot_q;
    end
    if (cmd.rd_node) begin
      scan_pass <= cmd.node_sel;
    end
  end

  // Adjacency scan, one bottom-store word per cycle.
  assign range_sum   = {2'b00, first_q} + {1'b0, deg_q};
  assign range_stop  = (range_sum > {1'b0, lim}) ? lim : range_sum[CNT_W-1:0];
  assign scan_more   = scan_idx < scan_stop;
  assign scan_target = scan_pass ? bot_a : bot_b;

  always_ff @(posedge clk) begin
    if (cmd.set_range) begin
      scan_idx  <= {1'b0, first_q};
      scan_stop <= range_stop;
    end else if (cmd.scan_step && scan_more) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
      scan_hit  <= 1'b0;
    end else begin
      scan_pend <= cmd.scan_step && scan_more;
      if (cmd.set_range) begin
        scan_hit <= 1'b0;
      end else if (scan_pend && (bot_q == scan_target)) begin
        scan_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      res_top <= '0;
      res_bot <= '0;
    end else if (cmd.cap_rd) begin
      res_top <= top_q;
      res_bot <= bot_q;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.status      <= res_status;
      out_item.read_top    <= res_top;
      out_item.read_bottom <= res_bot;
    end
  end

  assign sts.command      = item.command;
  assign sts.same_edge    = item.edge_a == item.edge_b;
  assign sts.out_of_range = ({1'b0, item.edge_a} >= lim) || ({1'b0, item.edge_b} >= lim);
  assign sts.scan_done    = scan_hit || (!scan_more && !scan_pend);
  assign sts.hit          = scan_hit;
  assign sts.out_free     = !out_valid || m_ready;

endmodule

`default_nettype wire

// ===== rtl/core/bes_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bes_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bes_pkg::dp_sts_t sts,
  output bes_pkg::dp_cmd_t cmd
);
  import bes_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_RDWAIT  = 4'd2;
  localparam logic [3:0] S_SW_RDB  = 4'd3;
  localparam logic [3:0] S_SW_CAPB = 4'd4;
  localparam logic [3:0] S_SETUP   = 4'd5;
  localparam logic [3:0] S_SCAN    = 4'd6;
  localparam logic [3:0] S_SWAP_A  = 4'd7;
  localparam logic [3:0] S_SWAP_B  = 4'd8;
  localparam logic [3:0] S_FINISH  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       pass;
  logic       pass_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    pass_next  = pass;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.command)
          CMD_WR_EDGE: begin
            cmd.wr_edge     = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DONE;
            state_next      = S_FINISH;
          end
          CMD_WR_NODE: begin
            cmd.wr_node     = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DONE;
            state_next      = S_FINISH;
          end
          CMD_SWAP: begin
            if (sts.same_edge) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_SAME;
              state_next      = S_FINISH;
            end else if (sts.out_of_range) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
              state_next      = S_FINISH;
            end else begin
              cmd.rd_a   = 1'b1;
              state_next = S_SW_RDB;
            end
          end
          default: begin
            cmd.rd_a        = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_DONE;
            state_next      = S_RDWAIT;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.cap_rd = 1'b1;
        state_next = S_FINISH;
      end
      S_SW_RDB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_b   = 1'b1;
        state_next = S_SW_CAPB;
      end
      S_SW_CAPB: begin
        cmd.cap_b    = 1'b1;
        cmd.rd_node  = 1'b1;
        cmd.node_sel = 1'b0;
        pass_next    = 1'b0;
        state_next   = S_SETUP;
      end
      S_SETUP: begin
        cmd.set_range = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (sts.hit) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_LINK;
          state_next      = S_FINISH;
        end else if (!pass) begin
          cmd.rd_node  = 1'b1;
          cmd.node_sel = 1'b1;
          pass_next    = 1'b1;
          state_next   = S_SETUP;
        end else begin
          state_next = S_SWAP_A;
        end
      end
      S_SWAP_A: begin
        cmd.wr_swap_a = 1'b1;
        state_next    = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.wr_swap_b   = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_SWAPPED;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`include "bipartite_edge_swap_engine_top_assert.svh"

  `BES_ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, sts.out_free)
  `BES_ASSERT_IMP(a_swap_pair, clk, rst, cmd.wr_swap_b, $past(cmd.wr_swap_a))
  `BES_ASSERT_IMP(a_no_swap_on_hit, clk, rst, cmd.wr_swap_a, !sts.hit)
  `BES_ASSERT_NXT(a_hit_ends_swap, clk, rst, state == S_SCAN && sts.hit, state == S_FINISH)

endmodule

`default_nettype wire

// ===== rtl/core/bipartite_edge_swap_engine_top.sv =====
// Items are taken one at a time. Each adjacency scan of a swap covers a clipped range
// of edges, and a link found ends it early.
// Reset (rst, synchronous, active high) clears the controller, edge_count, the scan
// flags and out_valid; the edge and node memories are not cleared and hold unknown data.
`timescale 1ns / 1ps
`default_nettype none

module bipartite_edge_swap_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration: edge_count, written whenever cfg_wr_en is high.
  input  logic                                cfg_wr_en,
  input  logic [bes_pkg::CNT_W-1:0]           cfg_wr_data,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // From bit 0: command[1:0], edge_a[15:0], edge_b[15:0], top_node[15:0],
  // bottom_node[15:0], first_edge[15:0], node_degree[16:0], zero padding.
  input  logic [bes_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // From bit 0: status[2:0], read_top[15:0], read_bottom[15:0], zero padding.
  output logic [bes_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import bes_pkg::*;

  localparam int IN_USED  = CMD_W + 4 * EDGE_AW + NODE_AW + CNT_W;
  localparam int OUT_USED = STATUS_W + 2 * NODE_AW;

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  // Unpack the input item, first field in the lowest bits.
  assign in_item.command     = s_axis_tdata[1:0];
  assign in_item.edge_a      = s_axis_tdata[17:2];
  assign in_item.edge_b      = s_axis_tdata[33:18];
  assign in_item.top_node    = s_axis_tdata[49:34];
  assign in_item.bottom_node = s_axis_tdata[65:50];
  assign in_item.first_edge  = s_axis_tdata[81:66];
  assign in_item.node_degree = s_axis_tdata[IN_USED-1:82];

  // The controller sequences every command; the datapath holds the memories,
  // the scan counters and the output register.
  bes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bes_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .m_ready     (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_item    (out_item)
  );

  // Pack the result item, status in the lowest bits.
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED){1'b0}},
                         out_item.read_bottom, out_item.read_top, out_item.status};

endmodule

`default_nettype wire
